>>> sv/name_value_pair_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// name_value_pair_tokenizer_macros.svh
// Assertion macros used by the tokenizer checker.
// ----------------------------------------------------------------------------
`ifndef NAME_VALUE_PAIR_TOKENIZER_MACROS_SVH
`define NAME_VALUE_PAIR_TOKENIZER_MACROS_SVH

// same-cycle implication, disabled during reset
`define NVPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nvpt assertion failed");

// next-cycle implication, disabled during reset
`define NVPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nvpt assertion failed");

`endif

>>> sv/nvpt_pkg.sv
// ----------------------------------------------------------------------------
// nvpt_pkg
// Types and character codes for the name/value pair tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package nvpt_pkg;

    localparam int BYTE_W = 8;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {
        ROLE_SEP    = 2'd0,
        ROLE_NAME   = 2'd1,
        ROLE_VALUE  = 2'd2,
        ROLE_SYNTAX = 2'd3
    } role_t;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_PAIR = 2'd1,
        ST_BAD  = 2'd2,
        ST_NONE = 2'd3
    } status_t;

    localparam byte_t CH_NUL   = 8'h00;
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_LF    = 8'h0A;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_DQ    = 8'h22;
    localparam byte_t CH_SQ    = 8'h27;
    localparam byte_t CH_COMMA = 8'h2C;
    localparam byte_t CH_SEMI  = 8'h3B;
    localparam byte_t CH_EQ    = 8'h3D;

    typedef struct packed {
        logic is_nul;
        logic is_eq;
        logic is_sep;
        logic is_dq;
        logic is_sq;
    } char_class_t;

endpackage

`default_nettype wire

>>> sv/nvpt_byte_if.sv
// ----------------------------------------------------------------------------
// nvpt_byte_if
// Text channel: one byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface nvpt_byte_if;
    logic            valid;
    logic            ready;
    nvpt_pkg::byte_t text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

>>> sv/nvpt_result_if.sv
// ----------------------------------------------------------------------------
// nvpt_result_if
// Result channel: byte role and pair status per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface nvpt_result_if;
    logic              valid;
    logic              ready;
    nvpt_pkg::role_t   byte_role;
    nvpt_pkg::status_t pair_status;

    modport source (output valid, output byte_role, output pair_status, input ready);
    modport sink   (input valid, input byte_role, input pair_status, output ready);
endinterface

`default_nettype wire

>>> sv/nvpt_char_class.sv
// ----------------------------------------------------------------------------
// nvpt_char_class
// Decodes one text byte into the character classes the parser uses.
// ----------------------------------------------------------------------------
`default_nettype none

module nvpt_char_class (
    input  wire nvpt_pkg::byte_t  text_byte,
    output nvpt_pkg::char_class_t cls
);

    always_comb
    begin
        cls.is_nul = (text_byte == nvpt_pkg::CH_NUL);
        cls.is_eq  = (text_byte == nvpt_pkg::CH_EQ);
        cls.is_dq  = (text_byte == nvpt_pkg::CH_DQ);
        cls.is_sq  = (text_byte == nvpt_pkg::CH_SQ);
        cls.is_sep = (text_byte == nvpt_pkg::CH_COMMA) || (text_byte == nvpt_pkg::CH_SEMI)
                  || (text_byte == nvpt_pkg::CH_SPACE) || (text_byte == nvpt_pkg::CH_TAB)
                  || (text_byte == nvpt_pkg::CH_LF)    || (text_byte == nvpt_pkg::CH_CR);
    end

endmodule

`default_nettype wire

>>> sv/nvpt_parse_core.sv
// ----------------------------------------------------------------------------
// nvpt_parse_core
// Parse state machine: advances one byte per step and registers its result.
// ----------------------------------------------------------------------------
`default_nettype none

module nvpt_parse_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire nvpt_pkg::char_class_t cls,
    output nvpt_pkg::role_t            byte_role,
    output nvpt_pkg::status_t          pair_status
);

    typedef enum logic [2:0] {
        MODE_BEFORE_NAME  = 3'd0,
        MODE_IN_NAME      = 3'd1,
        MODE_AFTER_NAME   = 3'd2,
        MODE_BEFORE_VALUE = 3'd3,
        MODE_IN_PLAIN     = 3'd4,
        MODE_IN_QUOTED    = 3'd5,
        MODE_IGNORE       = 3'd6
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic              dq_reg, dq_next;
    nvpt_pkg::role_t   role_reg, role_next;
    nvpt_pkg::status_t status_reg, status_next;
    logic              close_quote;

    assign close_quote = dq_reg ? cls.is_dq : cls.is_sq;

    always_comb
    begin
        mode_next   = mode_reg;
        dq_next     = dq_reg;
        role_next   = nvpt_pkg::ROLE_SEP;
        status_next = nvpt_pkg::ST_BUSY;
        unique case (mode_reg) inside
            MODE_IN_NAME, MODE_AFTER_NAME:
            begin
                if (cls.is_nul)
                begin
                    status_next = nvpt_pkg::ST_BAD;
                    mode_next   = MODE_BEFORE_NAME;
                end
                else if (cls.is_eq)
                begin
                    role_next = nvpt_pkg::ROLE_SYNTAX;
                    mode_next = MODE_BEFORE_VALUE;
                end
                else if (cls.is_sep)
                begin
                    mode_next = MODE_AFTER_NAME;
                end
                else if (mode_reg == MODE_IN_NAME)
                begin
                    role_next = nvpt_pkg::ROLE_NAME;
                end
                else
                begin
                    status_next = nvpt_pkg::ST_BAD;
                    mode_next   = MODE_IGNORE;
                end
            end
            MODE_BEFORE_VALUE:
            begin
                if (cls.is_nul)
                begin
                    status_next = nvpt_pkg::ST_PAIR;
                    mode_next   = MODE_BEFORE_NAME;
                end
                else if (cls.is_eq)
                begin
                    role_next   = nvpt_pkg::ROLE_SYNTAX;
                    status_next = nvpt_pkg::ST_PAIR;
                    mode_next   = MODE_BEFORE_NAME;
                end
                else if (cls.is_dq || cls.is_sq)
                begin
                    role_next = nvpt_pkg::ROLE_SYNTAX;
                    dq_next   = cls.is_dq;
                    mode_next = MODE_IN_QUOTED;
                end
                else if (!cls.is_sep)
                begin
                    role_next = nvpt_pkg::ROLE_VALUE;
                    mode_next = MODE_IN_PLAIN;
                end
            end
            MODE_IN_PLAIN:
            begin
                if (cls.is_nul || cls.is_sep)
                begin
                    status_next = nvpt_pkg::ST_PAIR;
                    mode_next   = MODE_BEFORE_NAME;
                end
                else if (cls.is_eq)
                begin
                    role_next   = nvpt_pkg::ROLE_SYNTAX;
                    status_next = nvpt_pkg::ST_PAIR;
                    mode_next   = MODE_BEFORE_NAME;
                end
                else
                begin
                    role_next = nvpt_pkg::ROLE_VALUE;
                end
            end
            MODE_IN_QUOTED:
            begin
                if (cls.is_nul)
                begin
                    status_next = nvpt_pkg::ST_PAIR;
                    mode_next   = MODE_BEFORE_NAME;
                end
                else if (close_quote)
                begin
                    role_next   = nvpt_pkg::ROLE_SYNTAX;
                    status_next = nvpt_pkg::ST_PAIR;
                    mode_next   = MODE_BEFORE_NAME;
                end
                else
                begin
                    role_next = nvpt_pkg::ROLE_VALUE;
                end
            end
            MODE_IGNORE:
            begin
                if (cls.is_nul)
                begin
                    mode_next = MODE_BEFORE_NAME;
                end
            end
            default:
            begin
                if (cls.is_nul)
                begin
                    status_next = nvpt_pkg::ST_NONE;
                    mode_next   = MODE_BEFORE_NAME;
                end
                else if (cls.is_eq)
                begin
                    role_next = nvpt_pkg::ROLE_SYNTAX;
                    mode_next = MODE_BEFORE_VALUE;
                end
                else if (cls.is_sep)
                begin
                    mode_next = MODE_BEFORE_NAME;
                end
                else
                begin
                    role_next = nvpt_pkg::ROLE_NAME;
                    mode_next = MODE_IN_NAME;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_BEFORE_NAME;
            dq_reg     <= 1'b0;
            role_reg   <= nvpt_pkg::ROLE_SEP;
            status_reg <= nvpt_pkg::ST_BUSY;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            dq_reg     <= dq_next;
            role_reg   <= role_next;
            status_reg <= status_next;
        end
    end

    assign byte_role   = role_reg;
    assign pair_status = status_reg;

endmodule

`default_nettype wire

>>> sv/name_value_pair_tokenizer.sv
// ----------------------------------------------------------------------------
// name_value_pair_tokenizer
// Tags each text byte and reports completed or malformed name=value pairs.
//
//   channel      dir   word contents
//   text_in      in    text_byte[7:0]
//   result_out   out   byte_role[1:0], pair_status[1:0]
//
// One byte per cycle sustained while result_out is not stalled; a word
// taken into the input register is parsed into the result register and
// can then leave on result_out.
// Reset clears both valid flags and returns the parser to before-name.
// A stall on result_out holds the result; text_in keeps taking one more
// byte into the input register, then drops ready until the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module name_value_pair_tokenizer (
    input  wire logic     clk,
    input  wire logic     rst_n,
    nvpt_byte_if.sink     text_in,
    nvpt_result_if.source result_out
);

    logic                  in_valid_reg, in_valid_next;
    nvpt_pkg::byte_t       byte_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  advance;
    logic                  take;
    nvpt_pkg::char_class_t cls;

    assign advance = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign text_in.ready = rst_n && (!in_valid_reg || advance);
    assign take = text_in.valid && text_in.ready;

    always_comb
    begin
        in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (result_out.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= text_in.text_byte;
        end
    end

    nvpt_char_class u_class (
        .text_byte (byte_reg),
        .cls       (cls)
    );

    nvpt_parse_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .cls         (cls),
        .byte_role   (result_out.byte_role),
        .pair_status (result_out.pair_status)
    );

    assign result_out.valid = out_valid_reg;

endmodule

`default_nettype wire

>>> sv/nvpt_checker.sv
// ----------------------------------------------------------------------------
// nvpt_checker
// Port-level checks for the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "name_value_pair_tokenizer_macros.svh"

module nvpt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  byte_role,
    input wire logic [1:0]  pair_status
);

    logic in_accept;

    assign in_accept = in_valid && in_ready;

    `NVPT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(byte_role) && $stable(pair_status))
    `NVPT_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)
    `NVPT_ASSERT_IMP(a_rise_after_take, clk, rst_n, $rose(out_valid), $past(in_accept, 2))
    `NVPT_ASSERT_IMP(a_none_is_sep, clk, rst_n, out_valid && (pair_status == nvpt_pkg::ST_NONE), byte_role == nvpt_pkg::ROLE_SEP)

endmodule

bind name_value_pair_tokenizer nvpt_checker u_nvpt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (text_in.valid),
    .in_ready    (text_in.ready),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .byte_role   (result_out.byte_role),
    .pair_status (result_out.pair_status)
);

`default_nettype wire
